[sv/bpa_pkg.sv]
// Shared types, constants and helper functions for the buddy page allocator.
// No dependencies; every other file of the block but bpa_ram imports this package.
package bpa_pkg;

	// Sizes of the managed chunk and of the free-list links.
	localparam int unsigned MAX_ORDER   = 11;
	localparam int unsigned CHUNK_PAGES = 1024;
	localparam int unsigned IDX_W       = 10;
	localparam int unsigned LINK_W      = 11;
	localparam int unsigned ORD_W       = 4;
	localparam int unsigned ROW_BITS    = 32;
	localparam int unsigned ROWS        = CHUNK_PAGES / ROW_BITS;
	localparam int unsigned ROW_W       = 5;
	localparam int unsigned CNT_W       = 6;

	localparam logic [LINK_W-1:0] LINK_NIL  = '1;
	localparam logic [ORD_W-1:0]  TOP_ORDER = 4'(MAX_ORDER - 1);
	localparam logic [ORD_W-1:0]  ROW_ORD   = 4'd5;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_LARGE   = 3'd2;
	localparam logic [2:0] ST_NOSPACE = 3'd3;
	localparam logic [2:0] ST_BADFREE = 3'd4;

	// Request word.
	typedef struct packed {
		logic        mode;
		logic [15:0] page_count;
		logic [9:0]  page_index;
		logic [3:0]  block_order;
	} alloc_in_t;

	// Response word.
	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  granted_index;
		logic [10:0] granted_pages;
	} alloc_out_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECODE,
		OP_A_RDN,
		OP_A_UNL,
		OP_SPLIT,
		OP_LINK1,
		OP_LINK2,
		OP_ROW_RD,
		OP_ROW_WR,
		OP_CHK_EV,
		OP_SET_WR,
		OP_M_TEST,
		OP_M_EV,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	// Status flags returned by the datapath.
	typedef struct packed {
		logic is_free;
		logic dec_err;
		logic split_more;
		logic h_valid;
		logic row_last;
		logic chk_bad;
		logic can_merge;
		logic merge_hit;
	} dp_status_t;

	// Bits of one row of the free map that a block covers.
	function automatic logic [ROW_BITS-1:0] row_mask(input logic [ORD_W-1:0] ord,
			input logic [ROW_W-1:0] off);
		logic [ROW_BITS-1:0] low;
		low = (32'd1 << (6'd1 << ord)) - 32'd1;
		if (ord >= ROW_ORD) begin
			row_mask = '1;
		end else begin
			row_mask = low << off;
		end
	endfunction

	// Number of free-map rows that a block covers.
	function automatic logic [CNT_W-1:0] row_count(input logic [ORD_W-1:0] ord);
		if (ord >= ROW_ORD) begin
			row_count = 6'd1 << (ord - ROW_ORD);
		end else begin
			row_count = 6'd1;
		end
	endfunction

endpackage

[sv/buddy_page_allocator.sv]
// Channel | Direction | Word type   | Handshake
// req     | in        | alloc_in_t  | req_valid / req_stall
// rsp     | out       | alloc_out_t | rsp_valid / rsp_stall
//
// One request at a time: req_stall stays high from acceptance until the response is written.
// Allocate unlinks a block, then splits it level by level and marks each free-map row it
// covers; free checks each covered row, sets each row, then merges level by level. The
// one-read-port free-map and link RAMs set the pace of each step. Size and alignment
// errors skip straight to the response.
// Reset is immediate, with no clearing pass. The response sits in a register, so
// a new request is taken while the previous response is still stalled.
module buddy_page_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  bpa_pkg::alloc_in_t  req,
	input  logic                req_valid,
	output logic                req_stall,
	output bpa_pkg::alloc_out_t rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);
	import bpa_pkg::*;

	cmd_t       cmd;
	dp_status_t sts;

	// Sequencer.
	bpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.sts(sts), .cmd(cmd));

	// Lists, memories and response register.
	bpa_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .req(req), .sts(sts), .rsp(rsp));

endmodule

[sv/bpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[sv/bpa_datapath.sv]
// Datapath of the buddy allocator: free lists, link and order memories,
// free-page map and the response register. Depends on bpa_pkg and bpa_ram.
module bpa_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpa_pkg::cmd_t          cmd,
	input  bpa_pkg::alloc_in_t     req,
	output bpa_pkg::dp_status_t    sts,
	output bpa_pkg::alloc_out_t    rsp
);
	import bpa_pkg::*;

	alloc_in_t          in_q;
	logic [2:0]         st_q;
	logic [ORD_W-1:0]   ord_q, found_q, cord_q, lk_ord_q;
	logic [IDX_W-1:0]   blk_q, cur_q, lk_blk_q, bud_q;
	logic [LINK_W-1:0]  lk_h_q;
	logic [ROW_W-1:0]   row_q, row0_q, rd_row_q;
	logic [CNT_W-1:0]   left_q, rtot_q;
	logic [ROW_BITS-1:0] mask_q, data_q;
	logic [LINK_W-1:0]  list_head_q [MAX_ORDER];
	logic [ROWS-1:0]    rvalid_q;
	logic               fresh_q;

	// Memory ports.
	logic               nx_we, pv_we, od_we, rw_we;
	logic [IDX_W-1:0]   nx_wa, pv_wa, od_wa, lk_ra;
	logic [LINK_W-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;
	logic [ORD_W-1:0]   od_wd, od_rd;
	logic [ROW_W-1:0]   rw_wa, rw_ra;
	logic [ROW_BITS-1:0] rw_wd, rw_rd, row_eff;

	// Decode results.
	logic [15:0]        cm1;
	logic [4:0]         aord;
	logic [ORD_W-1:0]   found_c;
	logic               fnd;
	logic [2:0]         dec_st;
	logic [IDX_W-1:0]   align_m, bud_c;
	logic [LINK_W-1:0]  h_c, nxt_c;
	logic               hit_c, bad_c;

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(CHUNK_PAGES)) u_next (
		.clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
		.rd_addr(lk_ra), .rd_data(nx_rd));
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(CHUNK_PAGES)) u_prev (
		.clk(clk), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
		.rd_addr(lk_ra), .rd_data(pv_rd));
	bpa_ram #(.WIDTH(ORD_W), .DEPTH(CHUNK_PAGES)) u_order (
		.clk(clk), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
		.rd_addr(lk_ra), .rd_data(od_rd));
	bpa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_rows (
		.clk(clk), .wr_en(rw_we), .wr_addr(rw_wa), .wr_data(rw_wd),
		.rd_addr(rw_ra), .rd_data(rw_rd));

	// Rows never written read as all pages free.
	assign row_eff = rvalid_q[rd_row_q] ? rw_rd : '1;
	assign bud_c   = cur_q ^ (10'd1 << cord_q);
	assign lk_ra   = (cmd.op == OP_A_RDN) ? blk_q : bud_c;
	assign rw_ra   = (cmd.op == OP_M_TEST) ? bud_c[IDX_W-1:ROW_W] : row_q;
	assign h_c     = list_head_q[lk_ord_q];
	assign nxt_c   = fresh_q ? LINK_NIL : nx_rd;
	assign hit_c   = row_eff[bud_q[ROW_W-1:0]] && (od_rd == cord_q);
	assign bad_c   = (row_eff & mask_q) != '0;

	// Request decode: order rounding, free-list search and free checks.
	always_comb begin
		cm1     = in_q.page_count - 16'd1;
		aord    = 5'd0;
		found_c = '0;
		fnd     = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (cm1[i]) begin
				aord = 5'(i + 1);
			end
		end
		for (int k = 0; k < MAX_ORDER; k++) begin
			if (!fnd && (5'(k) >= aord) && (list_head_q[k] != LINK_NIL)) begin
				found_c = 4'(k);
				fnd     = 1'b1;
			end
		end
		align_m = ~(10'h3FF << in_q.block_order);
		if (in_q.mode) begin
			if (in_q.block_order > TOP_ORDER || (in_q.page_index & align_m) != '0) begin
				dec_st = ST_BADFREE;
			end else begin
				dec_st = ST_OK;
			end
		end else if (in_q.page_count == 16'd0) begin
			dec_st = ST_ZERO;
		end else if (aord > 5'(TOP_ORDER)) begin
			dec_st = ST_LARGE;
		end else if (!fnd) begin
			dec_st = ST_NOSPACE;
		end else begin
			dec_st = ST_OK;
		end
	end

	// Status flags back to the controller.
	always_comb begin
		sts.is_free    = in_q.mode;
		sts.dec_err    = dec_st != ST_OK;
		sts.split_more = found_q > ord_q;
		sts.h_valid    = !h_c[LINK_W-1];
		sts.row_last   = left_q == 6'd1;
		sts.chk_bad    = bad_c;
		sts.can_merge  = cord_q < TOP_ORDER;
		sts.merge_hit  = hit_c;
	end

	// Memory write ports.
	always_comb begin
		nx_we = 1'b0; nx_wa = lk_blk_q; nx_wd = h_c;
		pv_we = 1'b0; pv_wa = lk_blk_q; pv_wd = LINK_NIL;
		od_we = 1'b0; od_wa = lk_blk_q; od_wd = lk_ord_q;
		rw_we = 1'b0; rw_wa = row_q;    rw_wd = row_eff & ~mask_q;
		case (cmd.op)
			OP_A_UNL: begin
				pv_we = !nxt_c[LINK_W-1];
				pv_wa = nxt_c[IDX_W-1:0];
			end
			OP_LINK1: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
				od_we = 1'b1;
			end
			OP_LINK2: begin
				pv_we = 1'b1;
				pv_wa = lk_h_q[IDX_W-1:0];
				pv_wd = {1'b0, lk_blk_q};
			end
			OP_ROW_WR: rw_we = 1'b1;
			OP_SET_WR: begin
				rw_we = 1'b1;
				rw_wd = data_q | mask_q;
			end
			OP_M_EV: begin
				nx_we = hit_c && !pv_rd[LINK_W-1];
				nx_wa = pv_rd[IDX_W-1:0];
				nx_wd = nx_rd;
				pv_we = hit_c && !nx_rd[LINK_W-1];
				pv_wa = nx_rd[IDX_W-1:0];
				pv_wd = pv_rd;
			end
			default: ;
		endcase
	end

	// Free-list heads, row valid bits and the untouched-chunk flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ORDER; k++) begin
				list_head_q[k] <= (k == MAX_ORDER - 1) ? '0 : LINK_NIL;
			end
			rvalid_q <= '0;
			fresh_q  <= 1'b1;
		end else begin
			case (cmd.op)
				OP_A_UNL: begin
					list_head_q[found_q] <= nxt_c;
					fresh_q <= 1'b0;
				end
				OP_LINK1: list_head_q[lk_ord_q] <= {1'b0, lk_blk_q};
				OP_ROW_WR, OP_SET_WR: rvalid_q[row_q] <= 1'b1;
				OP_M_EV: begin
					if (hit_c && pv_rd[LINK_W-1]) begin
						list_head_q[cord_q] <= nx_rd;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		rd_row_q <= rw_ra;
		case (cmd.op)
			OP_LOAD: in_q <= req;
			OP_DECODE: begin
				st_q    <= dec_st;
				ord_q   <= aord[ORD_W-1:0];
				found_q <= found_c;
				blk_q   <= list_head_q[found_c][IDX_W-1:0];
				cur_q   <= in_q.page_index;
				cord_q  <= in_q.block_order;
				row_q   <= in_q.page_index[IDX_W-1:ROW_W];
				row0_q  <= in_q.page_index[IDX_W-1:ROW_W];
				left_q  <= row_count(in_q.block_order);
				rtot_q  <= row_count(in_q.block_order);
				mask_q  <= row_mask(in_q.block_order, in_q.page_index[ROW_W-1:0]);
			end
			OP_SPLIT: begin
				if (found_q > ord_q) begin
					found_q  <= found_q - 4'd1;
					lk_blk_q <= blk_q | (10'd1 << (found_q - 4'd1));
					lk_ord_q <= found_q - 4'd1;
				end else begin
					row_q  <= blk_q[IDX_W-1:ROW_W];
					left_q <= row_count(ord_q);
					mask_q <= row_mask(ord_q, blk_q[ROW_W-1:0]);
				end
			end
			OP_LINK1: lk_h_q <= h_c;
			OP_ROW_WR, OP_SET_WR: begin
				row_q  <= row_q + 5'd1;
				left_q <= left_q - 6'd1;
			end
			OP_CHK_EV: begin
				data_q <= row_eff;
				if (bad_c) begin
					st_q <= ST_BADFREE;
				end else if (left_q == 6'd1) begin
					row_q  <= row0_q;
					left_q <= rtot_q;
				end else begin
					row_q  <= row_q + 5'd1;
					left_q <= left_q - 6'd1;
				end
			end
			OP_M_TEST: begin
				bud_q    <= bud_c;
				lk_blk_q <= cur_q;
				lk_ord_q <= cord_q;
			end
			OP_M_EV: begin
				if (hit_c) begin
					if (bud_q < cur_q) begin
						cur_q <= bud_q;
					end
					cord_q <= cord_q + 4'd1;
				end else begin
					lk_blk_q <= cur_q;
					lk_ord_q <= cord_q;
				end
			end
			OP_DONE: begin
				rsp.status        <= st_q;
				rsp.granted_index <= (st_q == ST_OK && !in_q.mode) ? blk_q : '0;
				rsp.granted_pages <= (st_q == ST_OK && !in_q.mode) ?
					(11'd1 << ord_q) : '0;
			end
			default: ;
		endcase
	end

endmodule

[sv/bpa_ctrl.sv]
// Controller state machine of the buddy allocator: sequences the datapath
// and runs both handshakes. Depends on bpa_pkg.
module bpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  bpa_pkg::dp_status_t sts,
	output bpa_pkg::cmd_t       cmd
);
	import bpa_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_DECODE = 15'h0002,
		S_A_RDN  = 15'h0004,
		S_A_UNL  = 15'h0008,
		S_SPLIT  = 15'h0010,
		S_LINK1  = 15'h0020,
		S_LINK2  = 15'h0040,
		S_ROW_RD = 15'h0080,
		S_ROW_WR = 15'h0100,
		S_CHK_RD = 15'h0200,
		S_CHK_EV = 15'h0400,
		S_SET_WR = 15'h0800,
		S_M_TEST = 15'h1000,
		S_M_EV   = 15'h2000,
		S_DONE   = 15'h4000
	} state_t;

	state_t state_q, state_nx;
	logic   rsp_valid_q;
	logic   out_free;
	state_t link_ret;

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign link_ret  = sts.is_free ? S_DONE : S_SPLIT;

	// Next state and datapath operation.
	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op = OP_DECODE;
				if (sts.dec_err) begin
					state_nx = S_DONE;
				end else if (sts.is_free) begin
					state_nx = S_CHK_RD;
				end else begin
					state_nx = S_A_RDN;
				end
			end
			S_A_RDN: begin
				cmd.op   = OP_A_RDN;
				state_nx = S_A_UNL;
			end
			S_A_UNL: begin
				cmd.op   = OP_A_UNL;
				state_nx = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.op   = OP_SPLIT;
				state_nx = sts.split_more ? S_LINK1 : S_ROW_RD;
			end
			S_LINK1: begin
				cmd.op   = OP_LINK1;
				state_nx = sts.h_valid ? S_LINK2 : link_ret;
			end
			S_LINK2: begin
				cmd.op   = OP_LINK2;
				state_nx = link_ret;
			end
			S_ROW_RD: begin
				cmd.op   = OP_ROW_RD;
				state_nx = S_ROW_WR;
			end
			S_ROW_WR: begin
				cmd.op   = OP_ROW_WR;
				state_nx = sts.row_last ? S_DONE : S_ROW_RD;
			end
			S_CHK_RD: begin
				cmd.op   = OP_ROW_RD;
				state_nx = S_CHK_EV;
			end
			S_CHK_EV: begin
				cmd.op = OP_CHK_EV;
				if (sts.chk_bad) begin
					state_nx = S_DONE;
				end else if (sts.row_last) begin
					state_nx = S_SET_WR;
				end else begin
					state_nx = S_CHK_RD;
				end
			end
			S_SET_WR: begin
				cmd.op   = OP_SET_WR;
				state_nx = sts.row_last ? S_M_TEST : S_SET_WR;
			end
			S_M_TEST: begin
				cmd.op   = OP_M_TEST;
				state_nx = sts.can_merge ? S_M_EV : S_LINK1;
			end
			S_M_EV: begin
				cmd.op   = OP_M_EV;
				state_nx = sts.merge_hit ? S_M_TEST : S_LINK1;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.op   = OP_DONE;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// State register and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == OP_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for buddy_page_allocator: directed and random allocate/free words.
// Depends on bpa_pkg for the request and response word types and the status codes.
module testbench;
	import bpa_pkg::*;

	localparam int NIL = 2047;

	typedef struct {
		alloc_in_t  word;
		alloc_out_t rsp;
		bit         hold;
	} pending_t;

	logic       clk;
	logic       arst_n;
	alloc_in_t  req;
	logic       req_valid;
	logic       req_stall;
	alloc_out_t rsp;
	logic       rsp_valid;
	logic       rsp_stall;

	// Shadow copy of the allocator state.
	bit pg_free [CHUNK_PAGES];
	int pg_ord  [CHUNK_PAGES];
	int nxt     [CHUNK_PAGES];
	int prv     [CHUNK_PAGES];
	int head    [MAX_ORDER];

	pending_t   pending_q[$];
	alloc_out_t rsp_q[$];
	alloc_out_t cur_rsp;
	int         live_idx[$];
	int         live_ord[$];
	int         fails;
	int         gap;
	int         stall_left;
	bit         calm;
	bit         done;

	buddy_page_allocator u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .req_valid(req_valid),
		.req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic report(input string what, input int got, input int want);
		fails++;
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	function automatic int idle_cycles();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic void list_unlink(int blk);
		int p;
		int n;
		p = prv[blk];
		n = nxt[blk];
		if (p < CHUNK_PAGES) nxt[p] = n;
		else head[pg_ord[blk]] = n;
		if (n < CHUNK_PAGES) prv[n] = p;
		nxt[blk] = NIL;
		prv[blk] = NIL;
	endfunction

	function automatic void list_push(int blk, int ord);
		pg_ord[blk] = ord;
		prv[blk] = NIL;
		nxt[blk] = head[ord];
		if (head[ord] < CHUNK_PAGES) prv[head[ord]] = blk;
		head[ord] = blk;
	endfunction

	function automatic void clear_pages();
		for (int i = 0; i < CHUNK_PAGES; i++) begin
			pg_free[i] = 1'b1;
			pg_ord[i] = 0;
			nxt[i] = NIL;
			prv[i] = NIL;
		end
		for (int k = 0; k < MAX_ORDER; k++) head[k] = NIL;
		list_push(0, MAX_ORDER - 1);
	endfunction

	// Works out the response word and updates the shadow state.
	function automatic alloc_out_t allocate_or_free(alloc_in_t w);
		alloc_out_t r;
		int ord;
		int found;
		int blk;
		int n;
		int bud;
		bit bad;
		r = '0;
		if (w.mode == 1'b0) begin
			ord = 0;
			while (ord < 17 && (1 << ord) < int'(w.page_count)) ord++;
			if (w.page_count == 0) r.status = ST_ZERO;
			else if (ord >= MAX_ORDER) r.status = ST_LARGE;
			else begin
				found = ord;
				while (found < MAX_ORDER && head[found] == NIL) found++;
				if (found >= MAX_ORDER) r.status = ST_NOSPACE;
				else begin
					blk = head[found];
					list_unlink(blk);
					while (found > ord) begin
						found--;
						list_push(blk + (1 << found), found);
					end
					for (int i = 0; i < (1 << ord); i++) begin
						pg_free[blk + i] = 1'b0;
						pg_ord[blk + i] = 0;
					end
					r.status = ST_OK;
					r.granted_index = blk[9:0];
					r.granted_pages = 11'(1 << ord);
				end
			end
		end else begin
			blk = w.page_index;
			ord = w.block_order;
			bad = ord >= MAX_ORDER;
			if (!bad) begin
				n = 1 << ord;
				bad = (blk & (n - 1)) != 0 || blk + n > CHUNK_PAGES;
			end
			if (!bad)
				for (int i = 0; i < n; i++) if (pg_free[blk + i]) bad = 1'b1;
			if (bad) r.status = ST_BADFREE;
			else begin
				for (int i = 0; i < n; i++) begin
					pg_free[blk + i] = 1'b1;
					pg_ord[blk + i] = 0;
				end
				while (ord + 1 < MAX_ORDER) begin
					bud = blk ^ (1 << ord);
					if (bud >= CHUNK_PAGES || !pg_free[bud] || pg_ord[bud] != ord) break;
					list_unlink(bud);
					pg_ord[bud] = 0;
					if (bud < blk) blk = bud;
					ord++;
				end
				list_push(blk, ord);
				r.status = ST_OK;
			end
		end
		return r;
	endfunction

	// Queues one word with its expected response, tracking granted blocks.
	task automatic queue_word(input alloc_in_t w, input bit hold = 1'b0);
		pending_t p;
		p.word = w;
		p.rsp = allocate_or_free(w);
		p.hold = hold;
		if (w.mode == 1'b0 && p.rsp.status == ST_OK) begin
			live_idx.push_back(p.rsp.granted_index);
			live_ord.push_back($clog2(p.rsp.granted_pages));
		end
		pending_q.push_back(p);
	endtask

	task automatic alloc_word(input int cnt, input bit hold = 1'b0);
		alloc_in_t w;
		w = alloc_in_t'(31'($urandom));
		w.mode = 1'b0;
		w.page_count = 16'(cnt);
		queue_word(w, hold);
	endtask

	task automatic free_word(input int idx, input int ord, input bit hold = 1'b0);
		alloc_in_t w;
		w = alloc_in_t'(31'($urandom));
		w.mode = 1'b1;
		w.page_index = 10'(idx);
		w.block_order = 4'(ord);
		queue_word(w, hold);
	endtask

	task automatic free_live(input int k);
		free_word(live_idx[k], live_ord[k]);
		live_idx.delete(k);
		live_ord.delete(k);
	endtask

	// Word driver: presents pending words and records the expected response on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				rsp_q.push_back(cur_rsp);
				if ($urandom_range(0, 39) == 0) calm = !calm;
			end
			if (req_valid && req_stall) begin
				// Stalled word stays as it is.
			end else if (gap > 0) begin
				gap <= gap - 1;
				req_valid <= 1'b0;
			end else if (pending_q.size() > 0 && !(pending_q[0].hold && rsp_q.size() > 0)) begin
				req <= pending_q[0].word;
				cur_rsp = pending_q[0].rsp;
				pending_q.delete(0);
				req_valid <= 1'b1;
				gap <= idle_cycles();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor: random stalls and comparison with the oldest expected word.
	always @(posedge clk or negedge arst_n) begin
		alloc_out_t want;
		int n;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			if (rsp_q.size() == 0) begin
				report("unexpected response word, status", rsp.status, -1);
			end else begin
				want = rsp_q.pop_front();
				if (rsp.status !== want.status) report("status", rsp.status, want.status);
				if (rsp.granted_index !== want.granted_index)
					report("granted_index", rsp.granted_index, want.granted_index);
				if (rsp.granted_pages !== want.granted_pages)
					report("granted_pages", rsp.granted_pages, want.granted_pages);
			end
			n = idle_cycles();
			stall_left <= n;
			rsp_stall <= n != 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= stall_left > 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int k;
		int r;
		fails = 0;
		calm = 1'b0;
		done = 1'b0;
		arst_n = 1'b0;
		clear_pages();

		// Directed: size errors, whole chunk, no space, bad frees and merges.
		alloc_word(0);
		alloc_word(1025);
		alloc_word(65535);
		alloc_word(1024);
		alloc_word(1);
		free_word(0, 11);
		free_word(0, 15);
		free_word(0, 10);
		free_word(0, 10);
		alloc_word(1);
		alloc_word(3);
		alloc_word(2);
		free_word(1023, 0);
		free_word(1, 1);
		free_word(1022, 1);
		alloc_word(512);
		alloc_word(257);
		alloc_word(1);
		while (live_idx.size() > 0) free_live(0);
		alloc_word(1023, 1'b1);
		free_live(0);

		// Random: mostly allocate/free of live blocks, some errors and noise.
		for (int i = 0; i < 450; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				k = $urandom_range(0, 9);
				if (k < 6) alloc_word($urandom_range(1, 16));
				else if (k < 8) alloc_word($urandom_range(1, 128));
				else if (k < 9) alloc_word($urandom_range(1, 1024));
				else alloc_word($urandom_range(0, 1) ? 0 : $urandom_range(1025, 65535));
			end else if (r < 92 && live_idx.size() > 0) begin
				free_live($urandom_range(0, live_idx.size() - 1));
			end else begin
				free_word($urandom_range(0, 1023), $urandom_range(0, 15));
			end
			if (i == 200) begin
				alloc_word(1, 1'b1);
			end
		end
		while (live_idx.size() > 0) free_live(0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0 && rsp_q.size() == 0 && !req_valid);
		repeat (150) @(posedge clk);
		if (rsp_q.size() != 0) fails++;
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		done = 1'b1;
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		if (!done) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
